// ===== src/lbst_pkg.sv =====
package lbst_pkg;

  localparam int KEYWORD_MAX_LEN_DEF = 8;
  localparam int LENGTH_BITS_DEF     = 16;

  localparam logic [3:0] K_IDENT   = 4'd0;
  localparam logic [3:0] K_KEYWORD = 4'd1;
  localparam logic [3:0] K_INT_DEC = 4'd2;
  localparam logic [3:0] K_INT_BIN = 4'd3;
  localparam logic [3:0] K_INT_OCT = 4'd4;
  localparam logic [3:0] K_INT_HEX = 4'd5;
  localparam logic [3:0] K_FLT_DEC = 4'd6;
  localparam logic [3:0] K_FLT_BIN = 4'd7;
  localparam logic [3:0] K_FLT_OCT = 4'd8;
  localparam logic [3:0] K_FLT_HEX = 4'd9;
  localparam logic [3:0] K_STRING  = 4'd10;
  localparam logic [3:0] K_OP      = 4'd11;
  localparam logic [3:0] K_END     = 4'd12;
  localparam logic [3:0] K_ERROR   = 4'd13;

  localparam logic [7:0] OP_ELLIPSIS = 8'd1;
  localparam logic [7:0] OP_CONCAT   = 8'd2;
  localparam logic [7:0] OP_DCOLON   = 8'd3;
  localparam logic [7:0] OP_LE       = 8'd4;
  localparam logic [7:0] OP_GE       = 8'd5;
  localparam logic [7:0] OP_EQEQ     = 8'd6;
  localparam logic [7:0] OP_NE       = 8'd7;

  localparam logic [1:0] EOL_LF     = 2'd0;
  localparam logic [1:0] EOL_CR     = 2'd1;
  localparam logic [1:0] EOL_CRLF   = 2'd2;
  // spare encoding, behaves as CR LF
  localparam logic [1:0] EOL_UNUSED = 2'd3;

  localparam logic [23:0] LINE_TOP = 24'hFFFFFF;
  localparam logic [15:0] COL_TOP  = 16'hFFFF;

  localparam int NUM_KW = 22;
  localparam logic [63:0] KW_TEXT [NUM_KW] = '{
    64'("and"), 64'("break"), 64'("do"), 64'("else"), 64'("elseif"), 64'("end"),
    64'("false"), 64'("for"), 64'("function"), 64'("goto"), 64'("if"), 64'("in"),
    64'("local"), 64'("nil"), 64'("not"), 64'("or"), 64'("repeat"), 64'("return"),
    64'("then"), 64'("true"), 64'("until"), 64'("while")
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd3, 4'd5, 4'd2, 4'd4, 4'd6, 4'd3, 4'd5, 4'd3, 4'd8, 4'd4, 4'd2,
    4'd2, 4'd5, 4'd3, 4'd3, 4'd2, 4'd6, 4'd6, 4'd4, 4'd4, 4'd5, 4'd5
  };

  typedef enum logic [4:0] {
    S_INIT, S_LCOM, S_DASH1, S_DASH2, S_DASH3, S_MLC, S_MLC_CLOSE,
    S_DOT1, S_DOT2, S_COLON, S_LT, S_GT, S_EQ, S_TILDE, S_IDENT,
    S_ZERO, S_ZERO_B, S_ZERO_X, S_BIN, S_OCT, S_DEC, S_HEX,
    S_FBIN, S_FOCT, S_FDEC, S_FHEX, S_STR, S_STR_ESC, S_HALT
  } scan_st_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  sub;
    logic [23:0] line;
    logic [15:0] col;
    logic [15:0] len;
  } tok_t;

  function automatic tok_t mk_tok(logic [3:0] kind, logic [7:0] sub, logic [23:0] line,
                                  logic [15:0] col, logic [15:0] len);
    tok_t t;
    t.kind = kind;
    t.sub  = sub;
    t.line = line;
    t.col  = col;
    t.len  = len;
    return t;
  endfunction

  function automatic logic [15:0] col_inc(logic [15:0] c);
    return (c != COL_TOP) ? c + 16'd1 : COL_TOP;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D || c == 8'h0B || c == 8'h0C;
  endfunction

  function automatic logic digit_ok(logic [7:0] c, logic [4:0] base);
    logic [7:0] d;
    d = c - "0";
    if (base == 5'd16) begin
      return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    end
    return c >= "0" && d < {3'd0, base};
  endfunction

  // bytes in the UTF-8 sequence a lead opens, 0 when the byte is no lead
  function automatic logic [2:0] lead_len(logic [7:0] c);
    if (c >= 8'hC0 && c <= 8'hDF) return 3'd2;
    if (c >= 8'hE0 && c <= 8'hEF) return 3'd3;
    if (c >= 8'hF0 && c <= 8'hF7) return 3'd4;
    return 3'd0;
  endfunction

  function automatic logic [4:0] num_base(scan_st_t s);
    case (s)
      S_BIN, S_FBIN: return 5'd2;
      S_OCT, S_FOCT: return 5'd8;
      S_HEX, S_FHEX: return 5'd16;
      default:       return 5'd10;
    endcase
  endfunction

  function automatic logic [3:0] num_kind(scan_st_t s);
    case (s)
      S_BIN:   return K_INT_BIN;
      S_OCT:   return K_INT_OCT;
      S_HEX:   return K_INT_HEX;
      S_FBIN:  return K_FLT_BIN;
      S_FOCT:  return K_FLT_OCT;
      S_FDEC:  return K_FLT_DEC;
      S_FHEX:  return K_FLT_HEX;
      default: return K_INT_DEC;
    endcase
  endfunction

  function automatic scan_st_t num_flt(scan_st_t s);
    case (s)
      S_BIN:   return S_FBIN;
      S_OCT:   return S_FOCT;
      S_HEX:   return S_FHEX;
      S_DEC:   return S_FDEC;
      default: return S_HALT;
    endcase
  endfunction

  // parallel keyword compare: {hit, index}
  function automatic logic [5:0] kw_find(logic [63:0] key, logic [3:0] len);
    logic [5:0] r;
    logic       eq;
    int         idx;
    r = 6'd0;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      eq = (len == KW_LEN[k]);
      for (int i = 0; i < 8; i++) begin
        idx = (int'(KW_LEN[k]) > i) ? int'(KW_LEN[k]) - 1 - i : 0;
        if (int'(KW_LEN[k]) > i && key[i*8 +: 8] != KW_TEXT[k][idx*8 +: 8]) eq = 1'b0;
      end
      if (eq) r = {1'b1, 5'(k)};
    end
    return r;
  endfunction

endpackage

// ===== src/lua_byte_stream_tokenizer_top.sv =====
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  in_data_byte, in_end_of_data
// out      output     out_valid/out_stall  token fields, out_last_of_run
// cfg      input      cfg_valid/cfg_ready  cfg_eol_mode
//
// One source byte per cycle is taken while out_stall is low; its tokens
// (0 to 3) are computed in the same cycle and land in a three-entry result
// buffer that drains one per cycle while out_stall is low. A byte giving at
// most one token keeps the byte rate; more hold the input until one is left.
// rst_n is synchronous, active low; cfg_ready is always high.
// in_stall rises only while the result buffer holds tokens that cannot all
// leave this cycle; out_stall holds the head token in place.
module lua_byte_stream_tokenizer_top #(
  parameter int KEYWORD_MAX_LEN = lbst_pkg::KEYWORD_MAX_LEN_DEF,
  parameter int LENGTH_BITS     = lbst_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_token_kind,
  output logic [7:0]  out_sub_code,
  output logic [23:0] out_start_line,
  output logic [15:0] out_start_column,
  output logic [15:0] out_token_length,
  output logic        out_last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_eol_mode
);
  import lbst_pkg::*;

  localparam int IW = $clog2(KEYWORD_MAX_LEN);
  localparam logic [LENGTH_BITS-1:0] LEN_TOP = '1;
  localparam logic [LENGTH_BITS-1:0] KMAX    = LENGTH_BITS'(KEYWORD_MAX_LEN);

  // scanner state
  scan_st_t                st_r, st_nxt;
  logic [8:0]              pb_r, pb_nxt;
  logic [23:0]             line_r, line_nxt;
  logic [15:0]             col_r, col_nxt;
  logic [23:0]             tsl_r, tsl_nxt;
  logic [15:0]             tsc_r, tsc_nxt;
  logic [LENGTH_BITS-1:0]  tl_r, tl_nxt;
  logic [1:0]              u8_r, u8_nxt;
  logic                    cr_r, cr_nxt;
  logic [7:0]              pfx_r [KEYWORD_MAX_LEN];
  logic [7:0]              pfx_nxt [KEYWORD_MAX_LEN];
  logic [1:0]              eol_mode_r;

  // result buffer
  tok_t                    slot_r [3];
  logic [1:0]              cnt_r;

  // candidate tokens of one byte, in emission order
  tok_t                    cand [6];
  logic [5:0]              cv;
  tok_t                    res [3];
  logic [1:0]              res_n;

  logic acc, take;

  function automatic logic [15:0] len16(logic [LENGTH_BITS-1:0] l);
    logic [31:0] w;
    w = 32'(l);
    return w[15:0];
  endfunction

  function automatic logic [63:0] pfx_key(logic [7:0] p [KEYWORD_MAX_LEN]);
    logic [63:0] k;
    for (int i = 0; i < 8; i++) k[i*8 +: 8] = p[i];
    return k;
  endfunction

  function automatic tok_t ident_tok(logic [7:0] p [KEYWORD_MAX_LEN],
                                     logic [LENGTH_BITS-1:0] l,
                                     logic [23:0] ln, logic [15:0] cl);
    logic [5:0] hit;
    logic [3:0] l4;
    l4  = (l <= LENGTH_BITS'(8)) ? l[3:0] : 4'd15;
    hit = kw_find(pfx_key(p), l4);
    if (hit[5]) return mk_tok(K_KEYWORD, {3'd0, hit[4:0]}, ln, cl, len16(l));
    return mk_tok(K_IDENT, 8'd0, ln, cl, len16(l));
  endfunction

  assign cfg_ready = 1'b1;
  assign out_valid = (cnt_r != 2'd0);
  assign take      = out_valid && !out_stall;
  assign in_stall  = !(cnt_r == 2'd0 || (cnt_r == 2'd1 && !out_stall));
  assign acc       = in_valid && !in_stall;

  assign out_token_kind   = slot_r[0].kind;
  assign out_sub_code     = slot_r[0].sub;
  assign out_start_line   = slot_r[0].line;
  assign out_start_column = slot_r[0].col;
  assign out_token_length = slot_r[0].len;
  assign out_last_of_run  = (cnt_r == 2'd1);

  always_comb begin
    logic [7:0]  c;
    logic        eol, swallow, brk, grow2;
    logic [2:0]  n;
    logic [7:0]  second, single, code;
    logic [23:0] ln;
    logic [15:0] cl;

    c       = in_data_byte;
    ln      = line_r;
    cl      = col_r;
    st_nxt  = st_r;
    pb_nxt  = pb_r;
    tsl_nxt = tsl_r;
    tsc_nxt = tsc_r;
    tl_nxt  = tl_r;
    u8_nxt  = u8_r;
    pfx_nxt = pfx_r;
    cv      = '0;
    for (int i = 0; i < 6; i++) cand[i] = '0;
    brk     = 1'b0;
    grow2   = 1'b0;
    second  = 8'd0;
    single  = 8'd0;
    code    = 8'd0;
    n       = 3'd0;

    // line end detection
    swallow = 1'b0;
    if (eol_mode_r == EOL_LF) begin
      eol = (c == 8'h0A);
    end else if (eol_mode_r == EOL_CR) begin
      eol = (c == 8'h0D);
    end else begin
      swallow = (c == 8'h0A) && cr_r;
      eol     = (c == 8'h0D) || (c == 8'h0A && !cr_r);
    end

    // invalid 0b / 0x: drop back to "0", then the letter opens an identifier
    if ((st_nxt == S_ZERO_B || st_nxt == S_ZERO_X) &&
        !digit_ok(c, (st_nxt == S_ZERO_B) ? 5'd2 : 5'd16)) begin
      cv[0]      = 1'b1;
      cand[0]    = mk_tok(K_INT_DEC, 8'd0, tsl_nxt, tsc_nxt, 16'd1);
      tsc_nxt    = col_inc(tsc_nxt);
      tl_nxt     = LENGTH_BITS'(1);
      pfx_nxt[0] = pb_r[7:0];
      pb_nxt     = 9'd0;
      u8_nxt     = 2'd0;
      st_nxt     = S_IDENT;
    end

    // current state takes the byte
    case (st_nxt)
      S_INIT: brk = 1'b1;
      S_LCOM: if (eol) st_nxt = S_INIT;
      S_DASH1: begin
        if (c == "-") begin
          st_nxt = S_DASH2;
        end else begin
          cv[1] = 1'b1; cand[1] = mk_tok(K_OP, "-", tsl_nxt, tsc_nxt, len16(tl_nxt));
          st_nxt = S_INIT; brk = 1'b1;
        end
      end
      S_DASH2, S_DASH3: begin
        if (c == "[") begin
          st_nxt = (st_nxt == S_DASH2) ? S_DASH3 : S_MLC;
        end else begin
          st_nxt = eol ? S_INIT : S_LCOM;
        end
      end
      S_MLC: if (c == "]") st_nxt = S_MLC_CLOSE;
      S_MLC_CLOSE: st_nxt = (c == "]") ? S_INIT : S_MLC;
      S_DOT1: begin
        if (c == ".") begin
          tl_nxt = LENGTH_BITS'(2); st_nxt = S_DOT2;
        end else begin
          cv[1] = 1'b1; cand[1] = mk_tok(K_OP, ".", tsl_nxt, tsc_nxt, len16(tl_nxt));
          st_nxt = S_INIT; brk = 1'b1;
        end
      end
      S_DOT2: begin
        st_nxt = S_INIT;
        cv[1]  = 1'b1;
        if (c == ".") begin
          tl_nxt  = LENGTH_BITS'(3);
          cand[1] = mk_tok(K_OP, OP_ELLIPSIS, tsl_nxt, tsc_nxt, 16'd3);
        end else begin
          cand[1] = mk_tok(K_OP, OP_CONCAT, tsl_nxt, tsc_nxt, len16(tl_nxt));
          brk     = 1'b1;
        end
      end
      S_COLON, S_LT, S_GT, S_EQ, S_TILDE: begin
        case (st_nxt)
          S_COLON: begin second = ":"; code = OP_DCOLON; single = ":"; end
          S_LT:    begin second = "="; code = OP_LE;     single = "<"; end
          S_GT:    begin second = "="; code = OP_GE;     single = ">"; end
          S_EQ:    begin second = "="; code = OP_EQEQ;   single = "="; end
          default: begin second = "="; code = OP_NE;     single = "~"; end
        endcase
        cv[1] = 1'b1;
        if (c == second) begin
          tl_nxt  = LENGTH_BITS'(2);
          cand[1] = mk_tok(K_OP, code, tsl_nxt, tsc_nxt, 16'd2);
        end else begin
          cand[1] = mk_tok(K_OP, single, tsl_nxt, tsc_nxt, len16(tl_nxt));
          brk     = 1'b1;
        end
        st_nxt = S_INIT;
      end
      S_IDENT: begin
        if (u8_nxt != 2'd0) begin
          u8_nxt = u8_nxt - 2'd1; grow2 = 1'b1;
        end else if (is_alpha(c) || is_digit(c)) begin
          grow2 = 1'b1;
        end else if (c >= 8'h80) begin
          n = lead_len(c);
          if (n == 3'd0) begin
            cv[1] = 1'b1; cand[1] = mk_tok(K_ERROR, 8'd0, ln, cl, 16'd0);
            st_nxt = S_HALT;
          end else begin
            grow2 = 1'b1; u8_nxt = 2'(n - 3'd1);
          end
        end else begin
          cv[1]   = 1'b1;
          cand[1] = ident_tok(pfx_nxt, tl_nxt, tsl_nxt, tsc_nxt);
          st_nxt  = S_INIT; brk = 1'b1;
        end
      end
      S_ZERO: begin
        if (c == "b" || c == "B") begin
          pb_nxt = {1'b1, c}; grow2 = 1'b1; st_nxt = S_ZERO_B;
        end else if (c == "x" || c == "X") begin
          pb_nxt = {1'b1, c}; grow2 = 1'b1; st_nxt = S_ZERO_X;
        end else if (is_digit(c)) begin
          grow2 = 1'b1; st_nxt = S_OCT;
        end else if (c == ".") begin
          grow2 = 1'b1; st_nxt = S_FDEC;
        end else begin
          cv[1] = 1'b1; cand[1] = mk_tok(K_INT_DEC, 8'd0, tsl_nxt, tsc_nxt, len16(tl_nxt));
          st_nxt = S_INIT; brk = 1'b1;
        end
      end
      S_ZERO_B, S_ZERO_X: begin
        // the digit case only: the invalid case was handled above
        pb_nxt = 9'd0; grow2 = 1'b1;
        st_nxt = (st_nxt == S_ZERO_B) ? S_BIN : S_HEX;
      end
      S_BIN, S_OCT, S_DEC, S_HEX, S_FBIN, S_FOCT, S_FDEC, S_FHEX: begin
        if (digit_ok(c, num_base(st_nxt))) begin
          grow2 = 1'b1;
        end else if (c == "." && num_flt(st_nxt) != S_HALT) begin
          grow2 = 1'b1; st_nxt = num_flt(st_nxt);
        end else begin
          cv[1]   = 1'b1;
          cand[1] = mk_tok(num_kind(st_nxt), 8'd0, tsl_nxt, tsc_nxt, len16(tl_nxt));
          st_nxt  = S_INIT; brk = 1'b1;
        end
      end
      S_STR: begin
        if (c == 8'h22) begin
          cv[1] = 1'b1; cand[1] = mk_tok(K_STRING, 8'd0, tsl_nxt, tsc_nxt, len16(tl_nxt));
          st_nxt = S_INIT;
        end else begin
          if (c == 8'h5C) st_nxt = S_STR_ESC;
          grow2 = 1'b1;
        end
      end
      S_STR_ESC: begin
        grow2 = 1'b1; st_nxt = S_STR;
      end
      default: ;
    endcase

    if (grow2) begin
      if (tl_nxt < KMAX) pfx_nxt[tl_nxt[IW-1:0]] = c;
      if (tl_nxt != LEN_TOP) tl_nxt = tl_nxt + LENGTH_BITS'(1);
    end

    // start of a new token
    if (brk && !is_space(c)) begin
      tsl_nxt = ln;
      tsc_nxt = cl;
      tl_nxt  = LENGTH_BITS'(1);
      if (c == "#" && ln == 24'd1 && cl == 16'd1) begin
        st_nxt = S_LCOM;
      end else begin
        case (c)
          "-": st_nxt = S_DASH1;
          ".": st_nxt = S_DOT1;
          ":": st_nxt = S_COLON;
          "<": st_nxt = S_LT;
          ">": st_nxt = S_GT;
          "=": st_nxt = S_EQ;
          "~": st_nxt = S_TILDE;
          "+", "*", "/", "%", "(", ")", ",", "&", "|", "^", "[", "]", "{", "}", ";", "#": begin
            cv[2] = 1'b1; cand[2] = mk_tok(K_OP, c, ln, cl, 16'd1);
          end
          "0": st_nxt = S_ZERO;
          8'h22: begin
            tl_nxt = '0; st_nxt = S_STR;
          end
          default: begin
            n = lead_len(c);
            if (c >= "1" && c <= "9") begin
              st_nxt = S_DEC;
            end else if (is_alpha(c) || n != 3'd0) begin
              pfx_nxt[0] = c;
              u8_nxt     = is_alpha(c) ? 2'd0 : 2'(n - 3'd1);
              st_nxt     = S_IDENT;
            end else begin
              cv[2] = 1'b1; cand[2] = mk_tok(K_ERROR, 8'd0, ln, cl, 16'd0);
              st_nxt = S_HALT;
            end
          end
        endcase
      end
    end

    // position of the next byte
    if (eol) begin
      line_nxt = (line_r != LINE_TOP) ? line_r + 24'd1 : LINE_TOP;
      col_nxt  = 16'd1;
    end else begin
      line_nxt = line_r;
      col_nxt  = swallow ? col_r : col_inc(col_r);
    end
    cr_nxt = (c == 8'h0D);

    // end of data: flush the pending token, add the end token unless halted, restart
    if (in_end_of_data) begin
      cv[3] = 1'b1;
      case (st_nxt)
        S_DASH1: cand[3] = mk_tok(K_OP, "-", tsl_nxt, tsc_nxt, len16(tl_nxt));
        S_DOT1:  cand[3] = mk_tok(K_OP, ".", tsl_nxt, tsc_nxt, len16(tl_nxt));
        S_DOT2:  cand[3] = mk_tok(K_OP, OP_CONCAT, tsl_nxt, tsc_nxt, len16(tl_nxt));
        S_COLON: cand[3] = mk_tok(K_OP, ":", tsl_nxt, tsc_nxt, len16(tl_nxt));
        S_LT:    cand[3] = mk_tok(K_OP, "<", tsl_nxt, tsc_nxt, len16(tl_nxt));
        S_GT:    cand[3] = mk_tok(K_OP, ">", tsl_nxt, tsc_nxt, len16(tl_nxt));
        S_EQ:    cand[3] = mk_tok(K_OP, "=", tsl_nxt, tsc_nxt, len16(tl_nxt));
        S_TILDE: cand[3] = mk_tok(K_OP, "~", tsl_nxt, tsc_nxt, len16(tl_nxt));
        S_ZERO:  cand[3] = mk_tok(K_INT_DEC, 8'd0, tsl_nxt, tsc_nxt, len16(tl_nxt));
        S_ZERO_B, S_ZERO_X: begin
          // "0" then a one-letter identifier, never a keyword
          cand[3] = mk_tok(K_INT_DEC, 8'd0, tsl_nxt, tsc_nxt, 16'd1);
          cv[4]   = 1'b1;
          cand[4] = mk_tok(K_IDENT, 8'd0, tsl_nxt, col_inc(tsc_nxt), 16'd1);
        end
        S_IDENT: begin
          if (u8_nxt != 2'd0) begin
            cand[3] = mk_tok(K_ERROR, 8'd0, tsl_nxt, tsc_nxt, 16'd0);
            st_nxt  = S_HALT;
          end else begin
            cand[3] = ident_tok(pfx_nxt, tl_nxt, tsl_nxt, tsc_nxt);
          end
        end
        S_BIN, S_OCT, S_DEC, S_HEX, S_FBIN, S_FOCT, S_FDEC, S_FHEX:
          cand[3] = mk_tok(num_kind(st_nxt), 8'd0, tsl_nxt, tsc_nxt, len16(tl_nxt));
        S_STR, S_STR_ESC: begin
          cand[3] = mk_tok(K_ERROR, 8'd0, tsl_nxt, tsc_nxt, 16'd0);
          st_nxt  = S_HALT;
        end
        default: cv[3] = 1'b0;
      endcase
      if (st_nxt != S_HALT) begin
        cv[5] = 1'b1; cand[5] = mk_tok(K_END, 8'd0, line_nxt, col_nxt, 16'd0);
      end
      st_nxt   = S_INIT;
      pb_nxt   = 9'd0;
      line_nxt = 24'd1;
      col_nxt  = 16'd1;
      tsl_nxt  = 24'd1;
      tsc_nxt  = 16'd1;
      tl_nxt   = '0;
      u8_nxt   = 2'd0;
      cr_nxt   = 1'b0;
    end

    // pack the candidates, keep the first three
    res_n = 2'd0;
    for (int i = 0; i < 3; i++) res[i] = '0;
    for (int i = 0; i < 6; i++) begin
      if (cv[i] && res_n != 2'd3) begin
        res[res_n] = cand[i];
        res_n      = res_n + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_INIT;
      pb_r       <= 9'd0;
      line_r     <= 24'd1;
      col_r      <= 16'd1;
      tsl_r      <= 24'd1;
      tsc_r      <= 16'd1;
      tl_r       <= '0;
      u8_r       <= 2'd0;
      cr_r       <= 1'b0;
      eol_mode_r <= EOL_LF;
      cnt_r      <= 2'd0;
    end else begin
      if (cfg_valid) eol_mode_r <= cfg_eol_mode;
      if (acc) begin
        // advance the scanner, replace the drained buffer
        st_r   <= st_nxt;
        pb_r   <= pb_nxt;
        line_r <= line_nxt;
        col_r  <= col_nxt;
        tsl_r  <= tsl_nxt;
        tsc_r  <= tsc_nxt;
        tl_r   <= tl_nxt;
        u8_r   <= u8_nxt;
        cr_r   <= cr_nxt;
        cnt_r  <= res_n;
      end else if (take) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // payload: prefix bytes and result slots need no reset
  always_ff @(posedge clk) begin
    if (acc) begin
      pfx_r  <= pfx_nxt;
      slot_r <= res;
    end else if (take) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= slot_r[2];
    end
  end

`ifndef SYNTH
  // a drained token shortens the buffer by one
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !acc) |=> cnt_r == $past(cnt_r) - 2'd1)
    else $error("result buffer count slipped");

  // a halted scanner stays silent until end of data
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && st_r == S_HALT && !in_end_of_data) |=> cnt_r == 2'd0)
    else $error("token after error");

  // end of data restarts scanner and position
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_end_of_data) |=> (st_r == S_INIT && line_r == 24'd1 && col_r == 16'd1))
    else $error("no restart after end of data");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import lbst_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  typedef struct {
    logic [3:0]  kind;
    logic [7:0]  sub;
    logic [23:0] line;
    logic [15:0] col;
    logic [15:0] len;
    logic        last;
  } token_t;

  typedef struct {
    logic [7:0] data;
    bit         eod;
    bit         typed;
    token_t     want;
  } stim_row_t;

  localparam token_t NO_TOKEN = '{4'd0, 8'd0, 24'd0, 16'd0, 16'd0, 1'b0};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_end_of_data = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_token_kind;
  logic [7:0]  out_sub_code;
  logic [23:0] out_start_line;
  logic [15:0] out_start_column;
  logic [15:0] out_token_length;
  logic        out_last_of_run;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_eol_mode = 2'd0;

  lua_byte_stream_tokenizer_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_data_byte(in_data_byte), .in_end_of_data(in_end_of_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_token_kind(out_token_kind), .out_sub_code(out_sub_code),
    .out_start_line(out_start_line), .out_start_column(out_start_column),
    .out_token_length(out_token_length), .out_last_of_run(out_last_of_run),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_eol_mode(cfg_eol_mode)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // tokens still owed by the block, oldest first
  token_t tokens_due_q[$];
  // tokens produced by the byte under prediction
  token_t byte_toks[$];
  int err_count = 0;
  int cyc = 0;

  // ---------------------------------------------------------------------------
  // Scanner mirror: state, position, current token and the line-end register
  // ---------------------------------------------------------------------------
  scan_st_t    sc_state;
  logic [8:0]  sc_push;
  logic [23:0] sc_line, sc_tline;
  logic [15:0] sc_col, sc_tcol, sc_len;
  logic [7:0]  sc_prefix [8];
  logic [2:0]  sc_utf;
  bit          sc_cr;
  logic [1:0]  sc_mode;

  string kw_list [22] = '{"and", "break", "do", "else", "elseif", "end", "false", "for",
    "function", "goto", "if", "in", "local", "nil", "not", "or", "repeat", "return",
    "then", "true", "until", "while"};

  function automatic bit letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit digit_in(logic [7:0] c, int base);
    logic [7:0] d;
    d = c - "0";
    if (base == 16) return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
                           (c >= "A" && c <= "F");
    return c >= "0" && d < base;
  endfunction

  function automatic int utf8_span(logic [7:0] c);
    if (c >= 8'hC0 && c <= 8'hDF) return 2;
    if (c >= 8'hE0 && c <= 8'hEF) return 3;
    if (c >= 8'hF0 && c <= 8'hF7) return 4;
    return 0;
  endfunction

  task automatic clear_scanner();
    sc_state = S_INIT;
    sc_push = 9'd0;
    sc_line = 24'd1;
    sc_col = 16'd1;
    sc_tline = 24'd1;
    sc_tcol = 16'd1;
    sc_len = 16'd0;
    foreach (sc_prefix[i]) sc_prefix[i] = 8'd0;
    sc_utf = 3'd0;
    sc_cr = 1'b0;
  endtask

  task automatic put_tok(logic [3:0] kind, logic [7:0] sub, logic [23:0] ln,
                         logic [15:0] cl, logic [15:0] len);
    token_t t;
    t = '{kind, sub, ln, cl, len, 1'b0};
    if (byte_toks.size() < 3) byte_toks.push_back(t);
  endtask

  task automatic emit_tok(logic [3:0] kind, logic [7:0] sub);
    put_tok(kind, sub, sc_tline, sc_tcol, sc_len);
  endtask

  task automatic error_tok(logic [23:0] ln, logic [15:0] cl);
    put_tok(K_ERROR, 8'd0, ln, cl, 16'd0);
    sc_state = S_HALT;
  endtask

  task automatic grow(logic [7:0] c);
    if (sc_len < 8) sc_prefix[sc_len] = c;
    if (sc_len != 16'hFFFF) sc_len++;
  endtask

  task automatic emit_word();
    bit hit;
    for (int k = 0; k < 22; k++) begin
      hit = (sc_len == kw_list[k].len());
      for (int i = 0; i < kw_list[k].len(); i++)
        if (sc_prefix[i] != kw_list[k][i]) hit = 0;
      if (hit) begin
        emit_tok(K_KEYWORD, 8'(k));
        return;
      end
    end
    emit_tok(K_IDENT, 8'd0);
  endtask

  task automatic num_props(scan_st_t s, output int base, output logic [3:0] kind,
                           output scan_st_t flt);
    case (s)
      S_BIN:   begin base = 2;  kind = K_INT_BIN; flt = S_FBIN; end
      S_OCT:   begin base = 8;  kind = K_INT_OCT; flt = S_FOCT; end
      S_HEX:   begin base = 16; kind = K_INT_HEX; flt = S_FHEX; end
      S_FBIN:  begin base = 2;  kind = K_FLT_BIN; flt = S_HALT; end
      S_FOCT:  begin base = 8;  kind = K_FLT_OCT; flt = S_HALT; end
      S_FDEC:  begin base = 10; kind = K_FLT_DEC; flt = S_HALT; end
      S_FHEX:  begin base = 16; kind = K_FLT_HEX; flt = S_HALT; end
      default: begin base = 10; kind = K_INT_DEC; flt = S_FDEC; end
    endcase
  endtask

  task automatic start_tok(logic [7:0] c, logic [23:0] ln, logic [15:0] cl);
    int n;
    if (c == " " || c == 8'h09 || c == CH_LF || c == CH_CR || c == 8'h0B || c == 8'h0C)
      return;
    sc_tline = ln;
    sc_tcol = cl;
    sc_len = 16'd1;
    if (c == "#" && ln == 24'd1 && cl == 16'd1) begin
      sc_state = S_LCOM;
      return;
    end
    case (c)
      "-": sc_state = S_DASH1;
      ".": sc_state = S_DOT1;
      ":": sc_state = S_COLON;
      "<": sc_state = S_LT;
      ">": sc_state = S_GT;
      "=": sc_state = S_EQ;
      "~": sc_state = S_TILDE;
      "+", "*", "/", "%", "(", ")", ",", "&", "|", "^", "[", "]", "{", "}", ";", "#":
        emit_tok(K_OP, c);
      "0": sc_state = S_ZERO;
      CH_QUOTE: begin
        sc_len = 16'd0;
        sc_state = S_STR;
      end
      default: begin
        if (c >= "1" && c <= "9") begin
          sc_state = S_DEC;
        end else if (letter(c)) begin
          sc_len = 16'd0;
          grow(c);
          sc_utf = 3'd0;
          sc_state = S_IDENT;
        end else begin
          n = utf8_span(c);
          if (n == 0) begin
            error_tok(ln, cl);
          end else begin
            sc_len = 16'd0;
            grow(c);
            sc_utf = 3'(n - 1);
            sc_state = S_IDENT;
          end
        end
      end
    endcase
  endtask

  // a "0b"/"0x" that went nowhere: report the zero, rescan the letter after it
  task automatic replay_zero();
    logic [7:0] b;
    logic [15:0] cl;
    b = sc_push[7:0];
    cl = (sc_tcol != 16'hFFFF) ? sc_tcol + 16'd1 : 16'hFFFF;
    sc_len = 16'd1;
    emit_tok(K_INT_DEC, 8'd0);
    sc_push = 9'd0;
    sc_state = S_INIT;
    start_tok(b, sc_tline, cl);
  endtask

  task automatic pair_tok(logic [7:0] c, logic [7:0] second, logic [7:0] code,
                          logic [7:0] single, output bit again);
    if (c == second) begin
      sc_len = 16'd2;
      emit_tok(K_OP, code);
    end else begin
      emit_tok(K_OP, single);
    end
    sc_state = S_INIT;
    again = (c != second);
  endtask

  task automatic scan_byte(logic [7:0] c, logic [23:0] ln, logic [15:0] cl, bit eol);
    bit again;
    int n, base;
    logic [3:0] kind;
    scan_st_t flt;
    again = 1;
    while (again) begin
      again = 0;
      case (sc_state)
        S_INIT: start_tok(c, ln, cl);
        S_LCOM: if (eol) sc_state = S_INIT;
        S_DASH1: begin
          if (c == "-") sc_state = S_DASH2;
          else begin emit_tok(K_OP, "-"); sc_state = S_INIT; again = 1; end
        end
        S_DASH2: begin
          if (c == "[") sc_state = S_DASH3;
          else begin sc_state = S_LCOM; again = 1; end
        end
        S_DASH3: begin
          if (c == "[") sc_state = S_MLC;
          else begin sc_state = S_LCOM; again = 1; end
        end
        S_MLC: if (c == "]") sc_state = S_MLC_CLOSE;
        S_MLC_CLOSE: sc_state = (c == "]") ? S_INIT : S_MLC;
        S_DOT1: begin
          if (c == ".") begin sc_len = 16'd2; sc_state = S_DOT2; end
          else begin emit_tok(K_OP, "."); sc_state = S_INIT; again = 1; end
        end
        S_DOT2: begin
          sc_state = S_INIT;
          if (c == ".") begin sc_len = 16'd3; emit_tok(K_OP, OP_ELLIPSIS); end
          else begin emit_tok(K_OP, OP_CONCAT); again = 1; end
        end
        S_COLON: pair_tok(c, ":", OP_DCOLON, ":", again);
        S_LT:    pair_tok(c, "=", OP_LE, "<", again);
        S_GT:    pair_tok(c, "=", OP_GE, ">", again);
        S_EQ:    pair_tok(c, "=", OP_EQEQ, "=", again);
        S_TILDE: pair_tok(c, "=", OP_NE, "~", again);
        S_IDENT: begin
          if (sc_utf != 3'd0) begin
            sc_utf--;
            grow(c);
          end else if (letter(c) || (c >= "0" && c <= "9")) begin
            grow(c);
          end else if (c >= 8'h80) begin
            n = utf8_span(c);
            if (n == 0) error_tok(ln, cl);
            else begin grow(c); sc_utf = 3'(n - 1); end
          end else begin
            emit_word();
            sc_state = S_INIT;
            again = 1;
          end
        end
        S_ZERO: begin
          if (c == "b" || c == "B") begin
            sc_push = {1'b1, c}; grow(c); sc_state = S_ZERO_B;
          end else if (c == "x" || c == "X") begin
            sc_push = {1'b1, c}; grow(c); sc_state = S_ZERO_X;
          end else if (c >= "0" && c <= "9") begin
            grow(c); sc_state = S_OCT;
          end else if (c == ".") begin
            grow(c); sc_state = S_FDEC;
          end else begin
            emit_tok(K_INT_DEC, 8'd0); sc_state = S_INIT; again = 1;
          end
        end
        S_ZERO_B, S_ZERO_X: begin
          if (digit_in(c, (sc_state == S_ZERO_B) ? 2 : 16)) begin
            sc_push = 9'd0;
            grow(c);
            sc_state = (sc_state == S_ZERO_B) ? S_BIN : S_HEX;
          end else begin
            replay_zero();
            again = 1;
          end
        end
        S_BIN, S_OCT, S_DEC, S_HEX, S_FBIN, S_FOCT, S_FDEC, S_FHEX: begin
          num_props(sc_state, base, kind, flt);
          if (digit_in(c, base)) grow(c);
          else if (c == "." && flt != S_HALT) begin grow(c); sc_state = flt; end
          else begin emit_tok(kind, 8'd0); sc_state = S_INIT; again = 1; end
        end
        S_STR: begin
          if (c == CH_QUOTE) begin
            emit_tok(K_STRING, 8'd0);
            sc_state = S_INIT;
          end else begin
            if (c == CH_BSLASH) sc_state = S_STR_ESC;
            grow(c);
          end
        end
        S_STR_ESC: begin grow(c); sc_state = S_STR; end
        default: ;
      endcase
    end
  endtask

  task automatic close_source();
    int base;
    logic [3:0] kind;
    scan_st_t flt;
    case (sc_state)
      S_DASH1: emit_tok(K_OP, "-");
      S_DOT1:  emit_tok(K_OP, ".");
      S_DOT2:  emit_tok(K_OP, OP_CONCAT);
      S_COLON: emit_tok(K_OP, ":");
      S_LT:    emit_tok(K_OP, "<");
      S_GT:    emit_tok(K_OP, ">");
      S_EQ:    emit_tok(K_OP, "=");
      S_TILDE: emit_tok(K_OP, "~");
      S_ZERO:  emit_tok(K_INT_DEC, 8'd0);
      S_ZERO_B, S_ZERO_X: begin replay_zero(); emit_word(); end
      S_IDENT: begin
        if (sc_utf != 3'd0) error_tok(sc_tline, sc_tcol);
        else emit_word();
      end
      S_BIN, S_OCT, S_DEC, S_HEX, S_FBIN, S_FOCT, S_FDEC, S_FHEX: begin
        num_props(sc_state, base, kind, flt);
        emit_tok(kind, 8'd0);
      end
      S_STR, S_STR_ESC: error_tok(sc_tline, sc_tcol);
      default: ;
    endcase
    if (sc_state != S_HALT) put_tok(K_END, 8'd0, sc_line, sc_col, 16'd0);
  endtask

  // work out the tokens one accepted source byte causes, into byte_toks
  task automatic tokenize_byte(logic [7:0] c, bit last);
    bit eol, swallow;
    byte_toks.delete();
    swallow = 0;
    if (sc_mode == EOL_LF) eol = (c == CH_LF);
    else if (sc_mode == EOL_CR) eol = (c == CH_CR);
    else begin
      swallow = (c == CH_LF) && sc_cr;
      eol = (c == CH_CR) || (c == CH_LF && !sc_cr);
    end
    scan_byte(c, sc_line, sc_col, eol);
    if (eol) begin
      if (sc_line != 24'hFFFFFF) sc_line++;
      sc_col = 16'd1;
    end else if (!swallow && sc_col != 16'hFFFF) begin
      sc_col++;
    end
    sc_cr = (c == CH_CR);
    if (last) begin
      close_source();
      clear_scanner();
    end
    if (byte_toks.size() > 0) byte_toks[$].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  function automatic int draw_wait();
    // mostly back to back, so long stretches run without idling
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
  endfunction

  // Drive one byte, wait for its transfer, then log what it should produce.
  // A typed row overrides the computed tokens with a value read off by hand.
  task automatic send_byte(logic [7:0] b, bit eod, bit typed, token_t want);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_end_of_data <= eod;
    do @(posedge clk); while (in_stall);
    tokenize_byte(b, eod);
    if (typed) begin
      byte_toks.delete();
      byte_toks.push_back(want);
    end
    foreach (byte_toks[i]) tokens_due_q.push_back(byte_toks[i]);
  endtask

  task automatic write_eol_mode(logic [1:0] m);
    cfg_valid <= 1'b1;
    cfg_eol_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sc_mode = m;
  endtask

  // drain every owed token, then give bytes without tokens time to retire
  task automatic drain_block();
    in_valid <= 1'b0;
    while (tokens_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Random Lua-like sources, {eod, byte} per entry
  // ---------------------------------------------------------------------------
  logic [8:0] src_q[$];

  string op_list [30] = '{"...", "..", "::", "<=", ">=", "==", "~=", "+", "-", "*", "/",
    "%", "(", ")", ",", "&", "|", "^", "[", "]", "{", "}", ";", "#", ".", ":", "<", ">",
    "=", "~"};

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) src_q.push_back({1'b0, s[i]});
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] rand_digit(int base);
    int r;
    r = $urandom_range(0, base - 1);
    if (r < 10) return 8'("0" + r);
    return ($urandom_range(0, 1) != 0) ? 8'("a" + r - 10) : 8'("A" + r - 10);
  endfunction

  task automatic push_digits(int base, int lo, int hi);
    repeat ($urandom_range(lo, hi)) src_q.push_back({1'b0, rand_digit(base)});
  endtask

  task automatic gen_source();
    int first, n;
    logic [7:0] lead;
    first = src_q.size();
    if ($urandom_range(0, 7) == 0) begin
      push_text("#!x");
      src_q.push_back({1'b0, ($urandom_range(0, 1) != 0) ? CH_LF : CH_CR});
    end
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          src_q.push_back({1'b0, rand_letter()});
          repeat ($urandom_range(0, 9)) begin
            if ($urandom_range(0, 7) == 0) begin
              n = $urandom_range(2, 4);
              lead = (n == 2) ? 8'($urandom_range(8'hC0, 8'hDF)) :
                     (n == 3) ? 8'($urandom_range(8'hE0, 8'hEF)) :
                                8'($urandom_range(8'hF0, 8'hF7));
              src_q.push_back({1'b0, lead});
              repeat (n - 1) src_q.push_back({1'b0, 8'($urandom_range(8'h80, 8'hBF))});
            end else if ($urandom_range(0, 3) == 0) begin
              src_q.push_back({1'b0, rand_digit(10)});
            end else begin
              src_q.push_back({1'b0, rand_letter()});
            end
          end
        end
        2: push_text(kw_list[$urandom_range(0, 21)]);
        3: begin
          case ($urandom_range(0, 7))
            0: begin src_q.push_back({1'b0, 8'($urandom_range("1", "9"))});
                     push_digits(10, 0, 4); end
            1: begin push_text(($urandom_range(0, 1) != 0) ? "0x" : "0X");
                     push_digits(16, 1, 4);
                     if ($urandom_range(0, 2) == 0) begin push_text("."); push_digits(16, 0, 3); end
               end
            2: begin push_text(($urandom_range(0, 1) != 0) ? "0b" : "0B");
                     push_digits(2, 1, 6);
                     if ($urandom_range(0, 2) == 0) begin push_text("."); push_digits(2, 0, 3); end
               end
            3: begin push_text("0"); push_digits(8, 1, 4);
                     if ($urandom_range(0, 2) == 0) begin push_text("."); push_digits(8, 0, 3); end
               end
            4: begin push_digits(10, 1, 3); push_text("."); push_digits(10, 0, 3); end
            5: begin push_text("0."); push_digits(10, 0, 3); end
            6: begin push_text(($urandom_range(0, 1) != 0) ? "0x" : "0b");
                     src_q.push_back({1'b0, rand_letter()}); end
            default: push_text("0");
          endcase
        end
        4: begin
          push_text("\"");
          repeat ($urandom_range(0, 8)) begin
            if ($urandom_range(0, 9) == 0) src_q.push_back({1'b0, CH_LF});
            else src_q.push_back({1'b0, 8'($urandom_range(8'h20, 8'h7E))});
          end
          if ($urandom_range(0, 7) != 0) push_text("\"");
        end
        5, 6: push_text(op_list[$urandom_range(0, 29)]);
        7: begin
          case ($urandom_range(0, 5))
            0: push_text(" ");
            1: src_q.push_back({1'b0, 8'h09});
            2: src_q.push_back({1'b0, CH_LF});
            3: src_q.push_back({1'b0, CH_CR});
            4: begin src_q.push_back({1'b0, CH_CR}); src_q.push_back({1'b0, CH_LF}); end
            default: src_q.push_back({1'b0, 8'($urandom_range(8'h0B, 8'h0C))});
          endcase
        end
        8: begin
          if ($urandom_range(0, 1) != 0) begin
            push_text("-- c");
            src_q.push_back({1'b0, ($urandom_range(0, 1) != 0) ? CH_LF : CH_CR});
          end else begin
            push_text("--[[ a");
            src_q.push_back({1'b0, CH_LF});
            push_text(($urandom_range(0, 3) != 0) ? "]]" : "]x]");
          end
        end
        default: src_q.push_back({1'b0, 8'($urandom())});
      endcase
      if ($urandom_range(0, 2) != 0) push_text(" ");
    end
    if (src_q.size() == first) push_text(" ");
    src_q[$][8] = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall per token, compare every transfer
  // ---------------------------------------------------------------------------
  int hold_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) hold_left = draw_wait();
      else if (hold_left > 0) hold_left--;
      out_stall <= (hold_left > 0);
    end
  end

  always @(posedge clk) begin
    token_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (tokens_due_q.size() == 0) begin
        $error("token with none due: kind %0d line %0d col %0d",
               out_token_kind, out_start_line, out_start_column);
        err_count++;
      end else begin
        w = tokens_due_q.pop_front();
        if (out_token_kind !== w.kind) begin
          $error("token_kind: expected %0d, got %0d", w.kind, out_token_kind); err_count++;
        end
        if (out_sub_code !== w.sub) begin
          $error("sub_code: expected %0d, got %0d", w.sub, out_sub_code); err_count++;
        end
        if (out_start_line !== w.line) begin
          $error("start_line: expected %0d, got %0d", w.line, out_start_line); err_count++;
        end
        if (out_start_column !== w.col) begin
          $error("start_column: expected %0d, got %0d", w.col, out_start_column);
          err_count++;
        end
        if (out_token_length !== w.len) begin
          $error("token_length: expected %0d, got %0d", w.len, out_token_length);
          err_count++;
        end
        if (out_last_of_run !== w.last) begin
          $error("last_of_run: expected %0d, got %0d", w.last, out_last_of_run); err_count++;
        end
      end
    end
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("lua_byte_stream_tokenizer_top regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed bytes, then random sources under each line-end convention
  // ---------------------------------------------------------------------------
  stim_row_t dir_tab[$];
  logic [1:0] mode_list [5] = '{EOL_CR, EOL_CRLF, EOL_LF, EOL_UNUSED, EOL_CRLF};

  initial begin
    dir_tab = '{
      // lone operator after reset
      '{8'h2B, 1'b0, 1'b1, '{K_OP, 8'h2B, 24'd1, 16'd1, 16'd1, 1'b1}},
      // stray continuation byte is an error, rest of the source is dropped
      '{8'h80, 1'b0, 1'b1, '{K_ERROR, 8'd0, 24'd1, 16'd2, 16'd0, 1'b1}},
      '{"a", 1'b1, 1'b0, NO_TOKEN},
      // dangling 0x with an operator as last byte: end token left out
      '{"0", 1'b0, 1'b0, NO_TOKEN},
      '{"x", 1'b0, 1'b0, NO_TOKEN},
      '{"+", 1'b1, 1'b0, NO_TOKEN},
      // shebang style comment at the first column of line one
      '{"#", 1'b0, 1'b0, NO_TOKEN},
      '{"y", 1'b0, 1'b0, NO_TOKEN},
      '{CH_LF, 1'b0, 1'b0, NO_TOKEN},
      '{"e", 1'b0, 1'b0, NO_TOKEN}, '{"l", 1'b0, 1'b0, NO_TOKEN},
      '{"s", 1'b0, 1'b0, NO_TOKEN}, '{"e", 1'b0, 1'b0, NO_TOKEN},
      '{"i", 1'b0, 1'b0, NO_TOKEN}, '{"f", 1'b0, 1'b0, NO_TOKEN},
      // invalid 0x followed by a letter
      '{"0", 1'b0, 1'b0, NO_TOKEN}, '{"X", 1'b0, 1'b0, NO_TOKEN},
      '{"g", 1'b0, 1'b0, NO_TOKEN},
      // string with an escaped quote
      '{CH_QUOTE, 1'b0, 1'b0, NO_TOKEN}, '{CH_BSLASH, 1'b0, 1'b0, NO_TOKEN},
      '{CH_QUOTE, 1'b0, 1'b0, NO_TOKEN}, '{CH_QUOTE, 1'b0, 1'b0, NO_TOKEN},
      // long comment spanning a line end
      '{"-", 1'b0, 1'b0, NO_TOKEN}, '{"-", 1'b0, 1'b0, NO_TOKEN},
      '{"[", 1'b0, 1'b0, NO_TOKEN}, '{"[", 1'b0, 1'b0, NO_TOKEN},
      '{CH_LF, 1'b0, 1'b0, NO_TOKEN}, '{"]", 1'b0, 1'b0, NO_TOKEN},
      '{"]", 1'b0, 1'b0, NO_TOKEN},
      // four-byte UTF-8 lead as the last byte: cut sequence at end of data
      '{8'hF7, 1'b1, 1'b0, NO_TOKEN}
    };

    sc_mode = EOL_LF;
    clear_scanner();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_byte(dir_tab[i].data, dir_tab[i].eod, dir_tab[i].typed,
                                   dir_tab[i].want);
    // byte with every bit set, alone in its source
    send_byte(8'hFF, 1'b1, 1'b0, NO_TOKEN);

    foreach (mode_list[m]) begin
      drain_block();
      write_eol_mode(mode_list[m]);
      src_q.delete();
      while (src_q.size() < 60) gen_source();
      foreach (src_q[i]) send_byte(src_q[i][7:0], src_q[i][8], 1'b0, NO_TOKEN);
    end

    drain_block();
    if (err_count == 0) begin
      $display("lua_byte_stream_tokenizer_top regression: pass");
    end else begin
      $display("lua_byte_stream_tokenizer_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== lua_byte_stream_tokenizer_top.f =====
src/lbst_pkg.sv
src/lua_byte_stream_tokenizer_top.sv
sim/tb.sv
